// ----- rtl/uvsp_pkg.sv -----
`timescale 1ns / 1ps
package uvsp_pkg;

  localparam int FRAC_BITS = 14;
  localparam int CNT_W     = 8;
  localparam logic [CNT_W-1:0] SEG_MIN  = CNT_W'(3);
  localparam logic [CNT_W-1:0] RING_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0] SEG_RESET  = CNT_W'(32);
  localparam logic [CNT_W-1:0] RING_RESET = CNT_W'(16);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_COUNT    = 2'd1;

  // Long divider: 8 quotient bits per stage
  localparam int DIV_NUM_W  = 48;
  localparam int DIV_DEN_W  = 10;
  localparam int DIV_BITS   = 8;
  localparam int DIV_STAGES = DIV_NUM_W / DIV_BITS;

  // Sine series in Q30
  localparam logic [30:0] PI_HALF_Q30  = 31'd1686629713;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam int TERMS = 6;
  localparam logic [7:0] TERM_DIV [TERMS] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
  localparam logic [31:0] TERM_RECIP [TERMS] = '{
    32'(64'h1_0000_0000 / 6),   32'(64'h1_0000_0000 / 20),
    32'(64'h1_0000_0000 / 42),  32'(64'h1_0000_0000 / 72),
    32'(64'h1_0000_0000 / 110), 32'(64'h1_0000_0000 / 156)};

  typedef struct packed {
    logic [DIV_DEN_W-1:0] rem;
    logic [DIV_BITS-1:0]  q;
  } div_step_t;

  typedef struct packed {
    logic        pv;
    logic        qv;
    logic [15:0] lo;
    logic [15:0] hi;
  } side_t;

  typedef struct packed {
    logic [16:0] tu;
    logic [16:0] tv;
  } tex_t;

  // Eight restoring steps of long division
  function automatic div_step_t div_step(input logic [DIV_DEN_W-1:0] rem_i,
                                         input logic [DIV_DEN_W-1:0] den,
                                         input logic [DIV_BITS-1:0] bits);
    logic [DIV_DEN_W:0] acc;
    div_step_t res;
    res.rem = rem_i;
    res.q   = '0;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      acc = {res.rem, bits[i]};
      if (acc >= {1'b0, den}) begin
        acc      = acc - {1'b0, den};
        res.q[i] = 1'b1;
      end
      res.rem = acc[DIV_DEN_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/uv_sphere_point_generator_top.sv -----
`timescale 1ns / 1ps
// UV sphere grid point generator, radius one half.
// Throughput: one item per cycle; busy is never raised and results cannot be held off.
// Reset (rst_n low, synchronous) clears all in-flight items and sets the
// counts to 32 segments and 16 rings.
module uv_sphere_point_generator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [7:0]                        in_ring_index,
  input  logic [7:0]                        in_segment_index,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [uvsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                        cfg_data,
  output logic                              out_valid,
  output logic                              out_point_valid,
  output logic signed [15:0]                out_normal_x,
  output logic signed [15:0]                out_normal_y,
  output logic signed [15:0]                out_normal_z,
  output logic signed [14:0]                out_pos_x,
  output logic signed [14:0]                out_pos_y,
  output logic signed [14:0]                out_pos_z,
  output logic [16:0]                       out_tex_u,
  output logic [16:0]                       out_tex_v,
  output logic                              out_quad_valid,
  output logic [15:0]                       out_corner_low,
  output logic [15:0]                       out_corner_high
);
  import uvsp_pkg::*;

  // Pipeline map, counted from the entry register (stage 0):
  //   stages 1..6   long dividers for both phases and both texture coordinates
  //   stages 7..28  four sine series (sin/cos of theta and phi)
  //   stage 29      normal products, stage 30 rounding into the output register
  localparam int SIDE_LEN = 29;
  localparam int TEX_LEN  = 23;
  localparam logic [15:0] LIM_N = 16'(1 << FRAC_BITS);
  localparam logic [15:0] LIM_P = 16'(1 << (FRAC_BITS - 1));

  logic [CNT_W-1:0] seg_cnt_r, ring_cnt_r;

  // Entry stage
  logic             e_vld_r;
  logic [7:0]       e_y_r, e_x_r, e_s_r, e_r_r;
  logic [CNT_W-1:0] s_used, r_used;

  logic [DIV_NUM_W-1:0] quo_t, quo_p, quo_u, quo_v;
  logic signed [33:0]   st, ct, sp, cp;

  logic [SIDE_LEN-1:0] vld_r;
  side_t               sd_r [SIDE_LEN];
  side_t               side_in;
  logic [15:0]         lo;
  tex_t                tx_r [TEX_LEN];
  tex_t                tex_in;

  logic signed [63:0] vx_r, vz_r, vy_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Hold counts; a write to an unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cnt_r  <= SEG_RESET;
      ring_cnt_r <= RING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SEGMENT_COUNT: seg_cnt_r  <= cfg_data;
        CFG_RING_COUNT:    ring_cnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Raise small counts to the minimum grid
  assign s_used = (seg_cnt_r < SEG_MIN) ? SEG_MIN : seg_cnt_r;
  assign r_used = (ring_cnt_r < RING_MIN) ? RING_MIN : ring_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= start && !busy;
    end
    e_y_r <= in_ring_index;
    e_x_r <= in_segment_index;
    e_s_r <= s_used;
    e_r_r <= r_used;
  end

  // Phase theta: (x*2^32 + S/2) / S; phase phi: (y*2^32 + R) / 2R
  uvsp_div u_div_t (
    .clk (clk),
    .num ((DIV_NUM_W'(e_x_r) << 32) + DIV_NUM_W'(e_s_r >> 1)),
    .den (DIV_DEN_W'(e_s_r)),
    .quo (quo_t)
  );
  uvsp_div u_div_p (
    .clk (clk),
    .num ((DIV_NUM_W'(e_y_r) << 32) + DIV_NUM_W'(e_r_r)),
    .den (DIV_DEN_W'({e_r_r, 1'b0})),
    .quo (quo_p)
  );
  // Texture coordinates, rounded half up
  uvsp_div u_div_u (
    .clk (clk),
    .num ((DIV_NUM_W'(e_x_r) << 16) + DIV_NUM_W'(e_s_r >> 1)),
    .den (DIV_DEN_W'(e_s_r)),
    .quo (quo_u)
  );
  uvsp_div u_div_v (
    .clk (clk),
    .num ((DIV_NUM_W'(e_y_r) << 16) + DIV_NUM_W'(e_r_r >> 1)),
    .den (DIV_DEN_W'(e_r_r)),
    .quo (quo_v)
  );

  // Cosine is the sine a quarter turn on
  uvsp_sin u_sin_t (.clk(clk), .ph(quo_t[31:0]),                .sin_o(st));
  uvsp_sin u_sin_ct(.clk(clk), .ph(quo_t[31:0] + QUARTER_TURN), .sin_o(ct));
  uvsp_sin u_sin_p (.clk(clk), .ph(quo_p[31:0]),                .sin_o(sp));
  uvsp_sin u_sin_cp(.clk(clk), .ph(quo_p[31:0] + QUARTER_TURN), .sin_o(cp));

  // Grid flags and corner indices travel alongside the arithmetic
  assign lo = 16'(16'(e_y_r) * (16'(e_s_r) + 16'd1)) + 16'(e_x_r);
  always_comb begin
    side_in.pv = (e_y_r <= e_r_r) && (e_x_r <= e_s_r);
    side_in.qv = (e_y_r < e_r_r) && (e_x_r < e_s_r);
    side_in.lo = lo;
    side_in.hi = side_in.qv ? (lo + 16'(e_s_r) + 16'd1) : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SIDE_LEN-2:0], e_vld_r};
    end
    sd_r[0] <= side_in;
    for (int i = 1; i < SIDE_LEN; i++) begin
      sd_r[i] <= sd_r[i-1];
    end
  end

  assign tex_in.tu = quo_u[16:0];
  assign tex_in.tv = 17'd65536 - quo_v[16:0];

  always_ff @(posedge clk) begin
    tx_r[0] <= tex_in;
    for (int i = 1; i < TEX_LEN; i++) begin
      tx_r[i] <= tx_r[i-1];
    end
  end

  // Normal products in Q60, cos phi stays in Q30
  always_ff @(posedge clk) begin
    vx_r <= 64'(signed'(ct[31:0])) * 64'(signed'(sp[31:0]));
    vz_r <= 64'(signed'(st[31:0])) * 64'(signed'(sp[31:0]));
    vy_r <= 64'(cp);
  end

  // Round half away from zero, then saturate symmetrically
  function automatic logic [15:0] rnd_sat(input logic signed [63:0] v, input int sh,
                                          input logic [15:0] lim);
    logic [63:0] mag;
    logic [63:0] r;
    logic [15:0] m16;
    mag = v[63] ? 64'(-v) : 64'(v);
    r   = (mag + (64'd1 << (sh - 1))) >> sh;
    m16 = (r > 64'(lim)) ? lim : r[15:0];
    return v[63] ? (16'd0 - m16) : m16;
  endfunction

  logic [15:0] nx, ny, nz, px, py, pz;
  assign nx = rnd_sat(vx_r, 60 - FRAC_BITS, LIM_N);
  assign ny = rnd_sat(vy_r, 30 - FRAC_BITS, LIM_N);
  assign nz = rnd_sat(vz_r, 60 - FRAC_BITS, LIM_N);
  assign px = rnd_sat(vx_r, 61 - FRAC_BITS, LIM_P);
  assign py = rnd_sat(vy_r, 31 - FRAC_BITS, LIM_P);
  assign pz = rnd_sat(vz_r, 61 - FRAC_BITS, LIM_P);

  // Output register; an item off the grid gives all-zero fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld_r[SIDE_LEN-1];
    end
    if (sd_r[SIDE_LEN-1].pv) begin
      out_point_valid <= 1'b1;
      out_normal_x    <= signed'(nx);
      out_normal_y    <= signed'(ny);
      out_normal_z    <= signed'(nz);
      out_pos_x       <= signed'(px[14:0]);
      out_pos_y       <= signed'(py[14:0]);
      out_pos_z       <= signed'(pz[14:0]);
      out_tex_u       <= tx_r[TEX_LEN-1].tu;
      out_tex_v       <= tx_r[TEX_LEN-1].tv;
      out_quad_valid  <= sd_r[SIDE_LEN-1].qv;
      out_corner_low  <= sd_r[SIDE_LEN-1].lo;
      out_corner_high <= sd_r[SIDE_LEN-1].hi;
    end else begin
      out_point_valid <= 1'b0;
      out_normal_x    <= '0;
      out_normal_y    <= '0;
      out_normal_z    <= '0;
      out_pos_x       <= '0;
      out_pos_y       <= '0;
      out_pos_z       <= '0;
      out_tex_u       <= '0;
      out_tex_v       <= '0;
      out_quad_valid  <= 1'b0;
      out_corner_low  <= '0;
      out_corner_high <= '0;
    end
  end

endmodule

// ----- rtl/uvsp_div.sv -----
`timescale 1ns / 1ps
module uvsp_div (
  input  logic                           clk,
  input  logic [uvsp_pkg::DIV_NUM_W-1:0] num,
  input  logic [uvsp_pkg::DIV_DEN_W-1:0] den,
  output logic [uvsp_pkg::DIV_NUM_W-1:0] quo
);
  import uvsp_pkg::*;

  logic [DIV_NUM_W-1:0] num_r [DIV_STAGES];
  logic [DIV_DEN_W-1:0] den_r [DIV_STAGES];
  logic [DIV_DEN_W-1:0] rem_r [DIV_STAGES];
  logic [DIV_NUM_W-1:0] quo_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIV_NUM_W-1:0] num_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [DIV_DEN_W-1:0] rem_in;
    logic [DIV_NUM_W-1:0] quo_in;
    div_step_t            st;

    if (s == 0) begin : g_first
      assign num_in = num;
      assign den_in = den;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign num_in = num_r[s-1];
      assign den_in = den_r[s-1];
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    // Take the next byte of the dividend from the top
    assign st = div_step(rem_in, den_in,
                         num_in[DIV_NUM_W-1-s*DIV_BITS -: DIV_BITS]);

    always_ff @(posedge clk) begin
      num_r[s] <= num_in;
      den_r[s] <= den_in;
      rem_r[s] <= st.rem;
      quo_r[s] <= {quo_in[DIV_NUM_W-DIV_BITS-1:0], st.q};
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

// ----- rtl/uvsp_sin.sv -----
`timescale 1ns / 1ps
module uvsp_sin (
  input  logic               clk,
  input  logic [31:0]        ph,
  output logic signed [33:0] sin_o
);
  import uvsp_pkg::*;

  // Fold to the first quadrant
  logic [30:0] t_r;
  logic        neg0_r;
  logic [31:0] x_r;
  logic        neg1_r;
  logic [31:0] term2_r, x2_2_r;
  logic signed [33:0] sum2_r;
  logic        neg2_r;
  logic [61:0] xp;
  logic [63:0] sq;

  // Per term: A multiply, B reciprocal multiply, C correct and accumulate
  logic [63:0]        am_r  [TERMS];
  logic [31:0]        ax2_r [TERMS];
  logic signed [33:0] asum_r[TERMS];
  logic               aneg_r[TERMS];
  logic [31:0]        bv_r  [TERMS];
  logic [63:0]        bp_r  [TERMS];
  logic [31:0]        bx2_r [TERMS];
  logic signed [33:0] bsum_r[TERMS];
  logic               bneg_r[TERMS];
  logic [31:0]        ct_r  [TERMS];
  logic [31:0]        cx2_r [TERMS];
  logic signed [33:0] csum_r[TERMS];
  logic               cneg_r[TERMS];

  assign xp = 62'(t_r) * 62'(PI_HALF_Q30);
  assign sq = 64'(x_r) * 64'(x_r);

  always_ff @(posedge clk) begin
    t_r     <= ph[30] ? (31'(QUARTER_TURN) - {1'b0, ph[29:0]}) : {1'b0, ph[29:0]};
    neg0_r  <= ph[31];
    x_r     <= xp[61:30];
    neg1_r  <= neg0_r;
    term2_r <= x_r;
    x2_2_r  <= sq[61:30];
    sum2_r  <= signed'(34'(x_r));
    neg2_r  <= neg1_r;
  end

  for (genvar k = 0; k < TERMS; k++) begin : g_term
    logic [31:0]        term_in;
    logic [31:0]        x2_in;
    logic signed [33:0] sum_in;
    logic               neg_in;
    logic [39:0]        rem;
    logic [31:0]        q_est;
    logic [31:0]        q;

    if (k == 0) begin : g_first
      assign term_in = term2_r;
      assign x2_in   = x2_2_r;
      assign sum_in  = sum2_r;
      assign neg_in  = neg2_r;
    end else begin : g_next
      assign term_in = ct_r[k-1];
      assign x2_in   = cx2_r[k-1];
      assign sum_in  = csum_r[k-1];
      assign neg_in  = cneg_r[k-1];
    end

    // Reciprocal estimate is at most one short
    assign q_est = bp_r[k][63:32];
    assign rem   = 40'(bv_r[k]) - 40'(q_est) * 40'(TERM_DIV[k]);
    assign q     = (rem >= 40'(TERM_DIV[k])) ? q_est + 32'd1 : q_est;

    always_ff @(posedge clk) begin
      am_r[k]   <= 64'(term_in) * 64'(x2_in);
      ax2_r[k]  <= x2_in;
      asum_r[k] <= sum_in;
      aneg_r[k] <= neg_in;
      bv_r[k]   <= am_r[k][61:30];
      bp_r[k]   <= 64'(am_r[k][61:30]) * 64'(TERM_RECIP[k]);
      bx2_r[k]  <= ax2_r[k];
      bsum_r[k] <= asum_r[k];
      bneg_r[k] <= aneg_r[k];
      ct_r[k]   <= q;
      cx2_r[k]  <= bx2_r[k];
      cneg_r[k] <= bneg_r[k];
      if (k % 2 == 0) begin
        csum_r[k] <= bsum_r[k] - signed'(34'(q));
      end else begin
        csum_r[k] <= bsum_r[k] + signed'(34'(q));
      end
    end
  end

  always_ff @(posedge clk) begin
    sin_o <= cneg_r[TERMS-1] ? -csum_r[TERMS-1] : csum_r[TERMS-1];
  end

endmodule
